>>> rtl/grid_four_neighbour_peak_finder_core_defines.svh
// Assertion macros for the four-neighbor peak finder.
// Included by the top level; needs signals named clock and reset in scope.
`ifndef GRID_FOUR_NEIGHBOUR_PEAK_FINDER_CORE_DEFINES_SVH
`define GRID_FOUR_NEIGHBOUR_PEAK_FINDER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define GFNPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define GFNPF_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GFNPF_ASSERT(lbl, prop, msg)
`define GFNPF_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

>>> rtl/gfnpf_pkg.sv
// Shared types and constants for the four-neighbor peak finder.
// No dependencies; imported by every module of the block.
package gfnpf_pkg;

   // default sizes
   localparam int DEFAULT_MAX_WIDTH  = 32;
   localparam int DEFAULT_MAX_HEIGHT = 1024;
   localparam int DEFAULT_ELEV_BITS  = 16;

   // register and result field widths
   localparam int GRID_WIDTH_BITS  = 6;
   localparam int GRID_HEIGHT_BITS = 11;
   localparam int PEAK_ROW_BITS    = 10;
   localparam int PEAK_COL_BITS    = 5;
   localparam int RSP_DATA_BITS    = 16;

   localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 6'd32;
   localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 11'd32;

   // register index (byte address bit 2)
   typedef enum logic {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   // request kind carried on tuser
   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

endpackage

>>> rtl/gfnpf_cell.sv
// One line-buffer cell: holds the older-row and middle-row elevation of one column.
// Depends on gfnpf_pkg; chained by the top level into a rotating row.
module gfnpf_cell
   import gfnpf_pkg::*;
#(
   parameter int ELEV_BITS = DEFAULT_ELEV_BITS
) (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic                        load_tail,
   input  logic signed [ELEV_BITS-1:0] right_old,
   input  logic signed [ELEV_BITS-1:0] right_mid,
   input  logic signed [ELEV_BITS-1:0] tail_old,
   input  logic signed [ELEV_BITS-1:0] tail_mid,
   output logic signed [ELEV_BITS-1:0] old_q,
   output logic signed [ELEV_BITS-1:0] mid_q
);

   logic signed [ELEV_BITS-1:0] old_ff, old_in;
   logic signed [ELEV_BITS-1:0] mid_ff, mid_in;

   // take the neighbor's column, or the freshly updated column at the wrap point
   always_comb begin
      old_in = load_tail ? tail_old : right_old;
      mid_in = load_tail ? tail_mid : right_mid;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         old_ff <= old_in;
         mid_ff <= mid_in;
      end
   end

   assign old_q = old_ff;
   assign mid_q = mid_ff;

endmodule

>>> rtl/gfnpf_rsp_buf.sv
// Result output register with one skid entry.
// Depends on gfnpf_pkg for the default data width.
module gfnpf_rsp_buf
   import gfnpf_pkg::*;
#(
   parameter int DATA_BITS = RSP_DATA_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic [DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [DATA_BITS-1:0] skid_data_ff, skid_data_in;

   // output register refills from skid first; new data parks in skid on a stall
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign has_room  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> rtl/grid_four_neighbour_peak_finder_core.sv
// Four-neighbor peak finder. Elevations stream in row-major order on req_*, one request
// per cycle; every cycle a request can be taken unless both the result register and its
// skid entry hold undelivered results. The line buffer is a row of MAX_WIDTH cells that
// rotates by one column per pixel or flush request, so the current column always sits in
// cell 0 and all four comparisons finish in the accept cycle; a peak result is registered
// and on rsp_* in the cycle after the request that settles it when no earlier result is
// still waiting, later while rsp_tready holds back the earlier results. A pixel at (r, c)
// settles cell (r-1, c);
// after the last row, grid_width flush requests (tuser = 1) settle the last row. Pixels
// after the grid is full and surplus or early flushes are dropped without a result. Any
// register write starts a new grid. There is no clearing pass after reset.
// Depends on gfnpf_pkg, gfnpf_cell, gfnpf_rsp_buf and the defines header.
`include "grid_four_neighbour_peak_finder_core_defines.svh"

module grid_four_neighbour_peak_finder_core
   import gfnpf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   parameter int ELEV_BITS  = DEFAULT_ELEV_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((ELEV_BITS + 7) / 8) * 8-1:0] req_tdata,  // [ELEV_BITS-1:0] elevation
   input  logic                                req_tuser,  // [0] func
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,  // [9:0] peak_row, [14:10] peak_col
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int WCW = (CW > GRID_WIDTH_BITS) ? CW : GRID_WIDTH_BITS;
   localparam int HCW = (HW > GRID_HEIGHT_BITS) ? HW : GRID_HEIGHT_BITS;

   // ---------------- configuration registers ----------------
   logic [GRID_WIDTH_BITS-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_BITS-1:0] grid_height_ff;
   logic                        csr_wr;
   csr_index_type               csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_pwdata[GRID_WIDTH_BITS-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_pwdata[GRID_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         CSR_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // effective size: zero acts as one, large values clamp to the maximum
   logic [WCW-1:0] width_ext;
   logic [HCW-1:0] height_ext;
   logic [CW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic [XW-1:0]  w_last;

   assign width_ext  = WCW'(grid_width_ff);
   assign height_ext = HCW'(grid_height_ff);

   always_comb begin
      if (grid_width_ff == '0) w_eff = CW'(1);
      else if (width_ext > WCW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_ext);
      if (grid_height_ff == '0) h_eff = HW'(1);
      else if (height_ext > HCW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(height_ext);
   end

   assign w_last = XW'(w_eff - CW'(1));

   // ---------------- request decode ----------------
   logic                        req_fire;
   logic                        is_flush;
   logic                        grid_full;
   logic                        pix_go;
   logic                        flush_go;
   logic                        shift_en;
   logic signed [ELEV_BITS-1:0] elev_in;

   logic [HW-1:0] row_ff, row_in;
   logic [XW-1:0] col_ff, col_in;
   logic [CW-1:0] flush_ff, flush_in;

   assign req_fire  = req_tvalid && req_tready;
   assign is_flush  = (func_type'(req_tuser) == FUNC_FLUSH);
   assign grid_full = (row_ff >= h_eff);
   assign pix_go    = req_fire && !is_flush && !grid_full;
   assign flush_go  = req_fire && is_flush && grid_full && (flush_ff < w_eff);
   assign shift_en  = pix_go || flush_go;
   assign elev_in   = signed'(req_tdata[ELEV_BITS-1:0]);

   // ---------------- line buffer: rotating row of cells ----------------
   logic signed [ELEV_BITS-1:0] old_q [MAX_WIDTH];
   logic signed [ELEV_BITS-1:0] mid_q [MAX_WIDTH];
   logic signed [ELEV_BITS-1:0] tail_old, tail_mid;
   logic signed [ELEV_BITS-1:0] right_mid;
   logic signed [ELEV_BITS-1:0] left_ff;

   // a pixel pushes middle into older and the new elevation into middle;
   // a flush only rotates the column through unchanged
   assign tail_old = flush_go ? old_q[0] : mid_q[0];
   assign tail_mid = flush_go ? mid_q[0] : elev_in;

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
      logic signed [ELEV_BITS-1:0] nb_old, nb_mid;
      logic                        load_tail;
      if (i == MAX_WIDTH - 1) begin : g_end
         assign nb_old    = tail_old;
         assign nb_mid    = tail_mid;
         assign load_tail = 1'b1;
      end else begin : g_mid
         assign nb_old    = old_q[i+1];
         assign nb_mid    = mid_q[i+1];
         assign load_tail = (w_last == XW'(i));
      end
      gfnpf_cell #(
         .ELEV_BITS (ELEV_BITS)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .load_tail (load_tail),
         .right_old (nb_old),
         .right_mid (nb_mid),
         .tail_old  (tail_old),
         .tail_mid  (tail_mid),
         .old_q     (old_q[i]),
         .mid_q     (mid_q[i])
      );
   end

   if (MAX_WIDTH > 1) begin : g_right
      assign right_mid = mid_q[1];
   end else begin : g_no_right
      assign right_mid = mid_q[0];
   end

   // middle value of the column just left behind, the left neighbor of the next one
   always_ff @(posedge clock) begin
      if (shift_en) left_ff <= mid_q[0];
   end

   // ---------------- peak test ----------------
   logic [XW-1:0]  pos;
   logic           has_up, has_left, has_right;
   logic           peak;
   logic           res_valid;
   logic [HW-1:0]  res_row;
   logic [31:0]    row_wide, col_wide;
   logic [RSP_DATA_BITS-1:0] res_data;

   assign pos       = flush_go ? XW'(flush_ff) : col_ff;
   assign has_up    = flush_go ? (h_eff != HW'(1)) : (row_ff > HW'(1));
   assign has_left  = (pos != '0);
   assign has_right = (pos != w_last);

   // ties do not disqualify; below neighbor exists only for pixels
   always_comb begin
      peak = 1'b1;
      if (has_up && (old_q[0] > mid_q[0])) peak = 1'b0;
      if (has_left && (left_ff > mid_q[0])) peak = 1'b0;
      if (has_right && (right_mid > mid_q[0])) peak = 1'b0;
      if (pix_go && (elev_in > mid_q[0])) peak = 1'b0;
   end

   assign res_valid = peak && (flush_go || (pix_go && (row_ff != '0)));
   assign res_row   = flush_go ? (h_eff - HW'(1)) : (row_ff - HW'(1));
   assign row_wide  = 32'(res_row);
   assign col_wide  = 32'(pos);
   assign res_data  = {1'b0, col_wide[PEAK_COL_BITS-1:0], row_wide[PEAK_ROW_BITS-1:0]};

   // ---------------- position counters ----------------
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      flush_in = flush_ff;
      if (csr_wr) begin
         row_in   = '0;
         col_in   = '0;
         flush_in = '0;
      end else begin
         if (pix_go) begin
            if (col_ff == w_last) begin
               col_in = '0;
               row_in = row_ff + HW'(1);
            end else begin
               col_in = col_ff + XW'(1);
            end
         end
         if (flush_go) flush_in = flush_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         flush_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         flush_ff <= flush_in;
      end
   end

   // ---------------- result buffer ----------------
   logic rsp_has_room;

   gfnpf_rsp_buf #(
      .DATA_BITS (RSP_DATA_BITS)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .has_room  (rsp_has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   assign req_tready = rsp_has_room;

   // ---------------- assertions ----------------
   `GFNPF_ASSERT_ALL(a_reset_clears, reset |=> (row_ff == '0 && col_ff == '0 && flush_ff == '0 && !rsp_tvalid), "positions or result not cleared by reset")
   `GFNPF_ASSERT(a_skid_behind_out, !rsp_has_room |-> rsp_tvalid, "skid entry full while result register empty")
   `GFNPF_ASSERT(a_col_in_row, col_ff <= w_last, "column position beyond grid width")
   `GFNPF_ASSERT(a_flush_after_grid, (flush_ff != '0) |-> (row_ff == h_eff && flush_ff <= w_eff), "flush count moved before grid was full")

endmodule

>>> bench/grid_four_neighbour_peak_finder_core_tb.sv
// Self-checking bench for the four-neighbor peak finder: streams grids of signed
// elevations, predicts every peak cell in software and compares each result in order.
// Depends on gfnpf_pkg and the grid_four_neighbour_peak_finder_core RTL.
`timescale 1ns / 1ps

module grid_four_neighbour_peak_finder_core_tb;
   import gfnpf_pkg::*;

   localparam int MAX_W         = DEFAULT_MAX_WIDTH;
   localparam int MAX_H         = DEFAULT_MAX_HEIGHT;
   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int ITEM_TARGET   = 2000;

   typedef struct packed {
      logic [PEAK_ROW_BITS-1:0] row;
      logic [PEAK_COL_BITS-1:0] col;
   } peak_cell_type;

   typedef enum int {ELEV_NARROW, ELEV_FULL, ELEV_EXTREME} elev_style_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] elevation
   logic        req_tuser = 1'b0; // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [9:0] peak_row, [14:10] peak_col
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grid_four_neighbour_peak_finder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Peak predictor: line buffers, scan position and register copies
   // ---------------------------------------------------------------
   logic signed [15:0]          older_row [MAX_W];
   logic signed [15:0]          middle_row [MAX_W];
   int unsigned                 cur_row;
   int unsigned                 cur_col;
   int unsigned                 flush_col;
   logic [GRID_WIDTH_BITS-1:0]  width_reg = GRID_WIDTH_RESET;
   logic [GRID_HEIGHT_BITS-1:0] height_reg = GRID_HEIGHT_RESET;
   peak_cell_type               expected_peaks [$];

   int error_count = 0;
   int items_sent = 0;

   // zero acts as one, oversize clamps to the maximum
   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return 32'(height_reg);
   endfunction

   // Advance the grid by one accepted request and queue the peak it settles, if any
   task automatic settle_request(input func_type kind, input logic signed [15:0] elev);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      logic signed [15:0] centre;
      bit is_peak;
      w = active_width();
      h = active_height();
      is_peak = 1'b1;
      if (kind == FUNC_PIXEL) begin
         if (cur_row >= h) return;   // grid already full
         r = cur_row;
         c = (cur_col >= w) ? 0 : cur_col;
         // pixel (r,c) settles cell (r-1,c)
         centre = middle_row[c];
         if (r >= 1) begin
            if (r >= 2 && older_row[c] > centre) is_peak = 1'b0;
            if (c > 0 && older_row[c-1] > centre) is_peak = 1'b0;
            if (c + 1 < w && middle_row[c+1] > centre) is_peak = 1'b0;
            if (elev > centre) is_peak = 1'b0;
            if (is_peak)
               expected_peaks.push_back(peak_cell_type'{row: PEAK_ROW_BITS'(r - 1),
                                                        col: PEAK_COL_BITS'(c)});
         end
         older_row[c]  = middle_row[c];
         middle_row[c] = elev;
         c++;
         if (c >= w) begin
            c = 0;
            cur_row = r + 1;
         end
         cur_col = c;
      end else begin
         // flushes only count once the grid is full, and only width of them
         if (cur_row < h || flush_col >= w) return;
         c = flush_col;
         flush_col++;
         centre = middle_row[c];
         if (h >= 2 && older_row[c] > centre) is_peak = 1'b0;
         if (c > 0 && middle_row[c-1] > centre) is_peak = 1'b0;
         if (c + 1 < w && middle_row[c+1] > centre) is_peak = 1'b0;
         if (is_peak)
            expected_peaks.push_back(peak_cell_type'{row: PEAK_ROW_BITS'(h - 1),
                                                     col: PEAK_COL_BITS'(c)});
      end
   endtask

   // ---------------------------------------------------------------
   // Result checker and watchdog
   // ---------------------------------------------------------------
   int            idle_cycles = 0;
   peak_cell_type want;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_peaks.size() == 0) begin
               $display("%0t: unexpected peak row %0d col %0d, none expected",
                        $time, rsp_tdata[9:0], rsp_tdata[14:10]);
               error_count++;
            end else begin
               want = expected_peaks.pop_front();
               if (rsp_tdata[9:0] !== want.row) begin
                  $display("%0t: peak_row mismatch: expected %0d, actual %0d",
                           $time, want.row, rsp_tdata[9:0]);
                  error_count++;
               end
               if (rsp_tdata[14:10] !== want.col) begin
                  $display("%0t: peak_col mismatch: expected %0d, actual %0d",
                           $time, want.col, rsp_tdata[14:10]);
                  error_count++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result-side stall pattern, with an optional long hold-off
   // ---------------------------------------------------------------
   bit             hold_request = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   int unsigned    stall_phase = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         stall_phase++;
         case (stall_mode)
            STALL_NONE:     rsp_tready = 1'b1;
            STALL_RANDOM:   rsp_tready = ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_tready = ((stall_phase % 7) >= 3);
            default:        rsp_tready = 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   bit steady_send = 1'b0;
   int burst_left = 0;

   // offer one request; bursts with random gaps unless steady_send is set
   task automatic send_request(input func_type kind, input logic [15:0] elev);
      int gap;
      @(negedge clock);
      if (!steady_send) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = elev;
      do @(posedge clock); while (!req_tready);
      settle_request(kind, elev);
      items_sent++;
   endtask

   // stop offering and wait for every outstanding peak
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_peaks.size() != 0) @(posedge clock);
   endtask

   // also covers requests that settle no peak but may still be in flight
   task automatic wait_until_idle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_register(input csr_index_type idx, input logic [31:0] want_value);
      logic [31:0] got;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got !== want_value) begin
         $display("%0t: register %s readback: expected %0d, actual %0d",
                  $time, idx.name(), want_value, got);
         error_count++;
      end
   endtask

   // any write restarts the grid scan
   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (idx)
         CSR_GRID_WIDTH:  width_reg  = value[GRID_WIDTH_BITS-1:0];
         CSR_GRID_HEIGHT: height_reg = value[GRID_HEIGHT_BITS-1:0];
         default: ;
      endcase
      cur_row   = 0;
      cur_col   = 0;
      flush_col = 0;
      read_register(idx, (idx == CSR_GRID_WIDTH) ? 32'(width_reg) : 32'(height_reg));
   endtask

   function automatic logic [15:0] pick_elevation(input elev_style_type style);
      logic signed [15:0] v;
      case (style)
         ELEV_NARROW: begin
            v = 16'($urandom_range(0, 4));
            v = v - 16'sd2;
         end
         ELEV_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       v = 16'sh8000;
               1:       v = 16'sh7fff;
               2:       v = 16'sh0000;
               3:       v = -16'sd1;
               default: v = 16'sh0001;
            endcase
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reset values, extremes, ties, early/late/extra flushes, clamped sizes
   task automatic test_directed_edges();
      logic [15:0] grid3 [9];
      grid3 = '{16'sd5, 16'sh8000, 16'sh7fff,
                16'sd5, 16'sd0, -16'sd1,
                16'sh8000, 16'sh7fff, 16'sh7fff};
      steady_send = 1'b0;
      // flushes before the default 32x32 grid is full are dropped
      send_request(FUNC_FLUSH, 16'hffff);
      send_request(FUNC_FLUSH, 16'h0000);
      wait_until_idle();
      read_register(CSR_GRID_WIDTH, 32'(GRID_WIDTH_RESET));
      read_register(CSR_GRID_HEIGHT, 32'(GRID_HEIGHT_RESET));
      // 3x3 grid with a flush in the middle of it and traffic after it is full
      write_register(CSR_GRID_WIDTH, 32'd3);
      write_register(CSR_GRID_HEIGHT, 32'd3);
      for (int k = 0; k < 9; k++) begin
         send_request(FUNC_PIXEL, grid3[k]);
         if (k == 4) send_request(FUNC_FLUSH, 16'h1234);
      end
      send_request(FUNC_PIXEL, 16'h7fff);
      for (int k = 0; k < 4; k++) send_request(FUNC_FLUSH, 16'h8000);
      wait_until_idle();
      // zero width and height both act as one
      write_register(CSR_GRID_WIDTH, 32'd0);
      write_register(CSR_GRID_HEIGHT, 32'd0);
      send_request(FUNC_PIXEL, 16'h8000);
      send_request(FUNC_PIXEL, 16'h7fff);
      send_request(FUNC_FLUSH, 16'h0000);
      send_request(FUNC_FLUSH, 16'h0000);
      wait_until_idle();
   endtask

   // flat grid, every cell a peak, while results are held off for a long stretch
   task automatic test_output_backpressure();
      logic [15:0] level;
      level = 16'($urandom);
      write_register(CSR_GRID_WIDTH, 32'd32);
      write_register(CSR_GRID_HEIGHT, 32'd8);
      steady_send  = 1'b1;
      hold_request = 1'b1;
      for (int k = 0; k < 32 * 8; k++) send_request(FUNC_PIXEL, level);
      for (int k = 0; k < 32; k++) send_request(FUNC_FLUSH, level);
      wait_until_idle();
      steady_send = 1'b0;
   endtask

   // sender stops mid-grid until every peak so far has come back
   task automatic test_drain_pause();
      write_register(CSR_GRID_WIDTH, 32'd4);
      write_register(CSR_GRID_HEIGHT, 32'd4);
      for (int k = 0; k < 16; k++) begin
         send_request(FUNC_PIXEL, pick_elevation(ELEV_NARROW));
         if (k == 8) wait_for_results();
      end
      for (int k = 0; k < 4; k++) send_request(FUNC_FLUSH, 16'($urandom));
      wait_until_idle();
   endtask

   // oversize height clamps to the maximum row count; single column
   task automatic test_tall_grid();
      write_register(CSR_GRID_WIDTH, 32'd0);
      write_register(CSR_GRID_HEIGHT, 32'd2047);
      for (int k = 0; k < MAX_H; k++) send_request(FUNC_PIXEL, pick_elevation(ELEV_NARROW));
      send_request(FUNC_PIXEL, 16'h7fff);
      send_request(FUNC_FLUSH, 16'h0000);
      send_request(FUNC_FLUSH, 16'h0000);
      wait_until_idle();
   endtask

   // one random grid: mostly complete scans, some cut short, some stray requests
   task automatic run_random_grid();
      logic [31:0] wv;
      logic [31:0] hv;
      int unsigned w;
      int unsigned h;
      int unsigned n_pix;
      int unsigned n_flush;
      elev_style_type style;
      bit broken;
      case ($urandom_range(0, 9))
         0:       wv = 0;
         1:       wv = $urandom_range(33, 63);
         2:       wv = 32;
         default: wv = $urandom_range(1, 32);
      endcase
      case ($urandom_range(0, 9))
         0:       hv = 0;
         1:       hv = 1;
         default: hv = $urandom_range(2, 6);
      endcase
      // junk above the register bits must be dropped
      if ($urandom_range(0, 1)) wv = wv | ($urandom << GRID_WIDTH_BITS);
      if ($urandom_range(0, 1)) hv = hv | ($urandom << GRID_HEIGHT_BITS);
      if ($urandom_range(0, 1)) begin
         write_register(CSR_GRID_WIDTH, wv);
         write_register(CSR_GRID_HEIGHT, hv);
      end else begin
         write_register(CSR_GRID_HEIGHT, hv);
         write_register(CSR_GRID_WIDTH, wv);
      end
      w = active_width();
      h = active_height();
      style = elev_style_type'($urandom_range(0, 2));
      steady_send = ($urandom_range(0, 3) == 0);
      broken = ($urandom_range(0, 7) == 0);
      n_pix = broken ? $urandom_range(0, w * h - 1) : w * h;
      for (int unsigned k = 0; k < n_pix; k++) begin
         if ($urandom_range(0, 19) == 0) send_request(FUNC_FLUSH, 16'($urandom));
         send_request(FUNC_PIXEL, pick_elevation(style));
         if (k == n_pix / 2 && $urandom_range(0, 9) == 0) wait_for_results();
      end
      if (!broken) begin
         if ($urandom_range(0, 3) == 0) send_request(FUNC_PIXEL, 16'($urandom));
         n_flush = w + $urandom_range(0, 2);
         for (int unsigned k = 0; k < n_flush; k++) send_request(FUNC_FLUSH, 16'($urandom));
      end
      wait_until_idle();
   endtask

   task automatic test_random_grids();
      while (items_sent < ITEM_TARGET) run_random_grid();
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      cur_row   = 0;
      cur_col   = 0;
      flush_col = 0;
      for (int k = 0; k < MAX_W; k++) begin
         older_row[k]  = '0;
         middle_row[k] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_output_backpressure();
      test_drain_pause();
      test_tall_grid();
      test_random_grids();

      wait_until_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_peaks.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gfnpf_pkg.sv
rtl/gfnpf_cell.sv
rtl/gfnpf_rsp_buf.sv
rtl/grid_four_neighbour_peak_finder_core.sv
bench/grid_four_neighbour_peak_finder_core_tb.sv
